// ===== rtl/tccs_pkg.sv =====
package tccs_pkg;

  // Field widths of the beats on the ports
  localparam int OP_W    = 1;
  localparam int CHAR_W  = 8;
  localparam int QROW_W  = 4;
  localparam int QCOL_W  = 6;
  localparam int GLYPH_W = 7;
  localparam int CROW_W  = 4;
  localparam int CCOL_W  = 6;

  localparam int ROWS_DEFAULT = 16;
  localparam int COLS_DEFAULT = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_PUT = 1'b0;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_MAX   = 8'd127;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 7'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_CURSOR = 7'd95;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_BS,
    CMD_PUT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [GLYPH_W-1:0] glyph;
    logic               newline;
    logic [QROW_W-1:0]  q_row;
    logic [QCOL_W-1:0]  q_col;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_CHAR,
    ST_CLR_LINE,
    ST_CLR_BOTTOM,
    ST_BS_BLANK,
    ST_WR_CURSOR,
    ST_READ,
    ST_RESP
  } back_state_e;

endpackage

// ===== rtl/tccs_front.sv =====
module tccs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tccs_pkg::OP_W-1:0]      op_i,
  input  logic [tccs_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [tccs_pkg::QROW_W-1:0]    query_row_i,
  input  logic [tccs_pkg::QCOL_W-1:0]    query_col_i,
  input  logic                           q_full_i,
  input  logic                           clearing_i,
  output logic                           push_o,
  output tccs_pkg::cmd_t                 cmd_o
);

  logic last_cr_q, last_cr_d;
  logic is_put;
  logic drop_lf;

  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  assign is_put  = (op_i == tccs_pkg::OP_PUT);
  assign drop_lf = last_cr_q && (char_in_i == tccs_pkg::CH_LF);

  always_comb begin
    cmd_o.q_row   = query_row_i;
    cmd_o.q_col   = query_col_i;
    cmd_o.newline = (char_in_i == tccs_pkg::CH_CR) || (char_in_i == tccs_pkg::CH_LF);
    if (char_in_i inside {[tccs_pkg::CH_SPACE:tccs_pkg::CH_MAX]}) begin
      cmd_o.glyph = char_in_i[tccs_pkg::GLYPH_W-1:0];
    end else begin
      cmd_o.glyph = tccs_pkg::GLYPH_SPACE;
    end
    // a line feed that follows a carriage return becomes a plain read
    if (!is_put || drop_lf) begin
      cmd_o.kind = tccs_pkg::CMD_READ;
    end else if (char_in_i == tccs_pkg::CH_BS) begin
      cmd_o.kind = tccs_pkg::CMD_BS;
    end else begin
      cmd_o.kind = tccs_pkg::CMD_PUT;
    end
  end

  always_comb begin
    last_cr_d = last_cr_q;
    if (push_o && is_put) begin
      last_cr_d = drop_lf ? 1'b0 : (char_in_i == tccs_pkg::CH_CR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cr_q <= 1'b0;
    end else begin
      last_cr_q <= last_cr_d;
    end
  end

endmodule

// ===== rtl/tccs_fifo.sv =====
module tccs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tccs_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tccs_pkg::cmd_t data_o
);

  localparam int Depth = tccs_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tccs_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/tccs_back.sv =====
module tccs_back #(
  parameter int ROWS = tccs_pkg::ROWS_DEFAULT,
  parameter int COLS = tccs_pkg::COLS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  tccs_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tccs_pkg::GLYPH_W-1:0]  cell_glyph_o,
  output logic [tccs_pkg::CROW_W-1:0]   cursor_row_o,
  output logic [tccs_pkg::CCOL_W-1:0]   cursor_col_o,
  output logic                          scrolled_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int Depth = ROWS * (1 << CW);

  tccs_pkg::back_state_e state_q, state_d;
  tccs_pkg::cmd_t        cmd_q, cmd_d;

  logic [RW-1:0] row_q, row_d, top_q, top_d;
  logic [CW-1:0] col_q, col_d, scan_q, scan_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          scrolled_q, scrolled_d;
  logic          q_ok_q, q_ok_d;

  logic [tccs_pkg::GLYPH_W-1:0] mem [Depth];
  logic [tccs_pkg::GLYPH_W-1:0] rdata_q;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [tccs_pkg::GLYPH_W-1:0] mem_wdata;

  logic                         out_valid_q, out_valid_d;
  logic [tccs_pkg::GLYPH_W-1:0] out_glyph_q, out_glyph_d;
  logic [tccs_pkg::CROW_W-1:0]  out_row_q, out_row_d;
  logic [tccs_pkg::CCOL_W-1:0]  out_col_q, out_col_d;
  logic                         out_scr_q, out_scr_d;
  logic                         out_free;

  logic [CW:0]                  col_inc;
  logic                         at_last_row;
  logic [RW-1:0]                top_inc;
  tccs_pkg::back_state_e        adv_state;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] vrow,
                                              input logic [RW-1:0] top,
                                              input logic [CW-1:0] col);
    logic [RW:0] sum;
    sum = {1'b0, vrow} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return {sum[RW-1:0], col};
  endfunction

  assign clearing_o   = (state_q == tccs_pkg::ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign cell_glyph_o = out_glyph_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;
  assign out_free     = ~out_valid_q | ~out_stall_i;

  assign col_inc     = {1'b0, col_q} + (CW+1)'(1);
  assign at_last_row = (row_q == RW'(ROWS - 1));
  assign top_inc     = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
  assign adv_state   = at_last_row ? tccs_pkg::ST_CLR_BOTTOM : tccs_pkg::ST_WR_CURSOR;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    scan_d      = scan_q;
    clr_d       = clr_q;
    scrolled_d  = scrolled_q;
    q_ok_d      = q_ok_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr(row_q, top_q, col_q);
    mem_wdata   = tccs_pkg::GLYPH_SPACE;
    mem_re      = 1'b0;
    mem_raddr   = cell_addr(RW'(cmd_q.q_row), top_q, CW'(cmd_q.q_col));
    out_valid_d = out_valid_q & out_stall_i;
    out_glyph_d = out_glyph_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_scr_d   = out_scr_q;

    case (state_q)
      tccs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? tccs_pkg::GLYPH_CURSOR : tccs_pkg::GLYPH_SPACE;
        if (clr_q == AW'(Depth - 1)) begin
          state_d = tccs_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      tccs_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          scrolled_d = 1'b0;
          case (cmd_i.kind)
            tccs_pkg::CMD_PUT: state_d = tccs_pkg::ST_WR_CHAR;
            tccs_pkg::CMD_BS:  state_d = tccs_pkg::ST_BS_BLANK;
            default:           state_d = tccs_pkg::ST_READ;
          endcase
        end
      end
      tccs_pkg::ST_WR_CHAR: begin
        mem_we    = 1'b1;
        mem_wdata = cmd_q.glyph;
        if (cmd_q.newline || (col_inc >= (CW+1)'(COLS))) begin
          if (col_inc < (CW+1)'(COLS)) begin
            scan_d  = CW'(col_inc);
            state_d = tccs_pkg::ST_CLR_LINE;
          end else begin
            // next row, or scroll when already on the bottom row
            col_d   = '0;
            scan_d  = '0;
            state_d = adv_state;
            if (at_last_row) begin
              top_d      = top_inc;
              scrolled_d = 1'b1;
            end else begin
              row_d = row_q + RW'(1);
            end
          end
        end else begin
          col_d   = CW'(col_inc);
          state_d = tccs_pkg::ST_WR_CURSOR;
        end
      end
      tccs_pkg::ST_CLR_LINE: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_q, top_q, scan_q);
        if (scan_q == CW'(COLS - 1)) begin
          col_d   = '0;
          scan_d  = '0;
          state_d = adv_state;
          if (at_last_row) begin
            top_d      = top_inc;
            scrolled_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      tccs_pkg::ST_CLR_BOTTOM: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_q, top_q, scan_q);
        if (scan_q == CW'(COLS - 1)) begin
          state_d = tccs_pkg::ST_WR_CURSOR;
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      tccs_pkg::ST_BS_BLANK: begin
        mem_we = 1'b1;
        if (col_q != '0) begin
          col_d = col_q - CW'(1);
        end
        state_d = tccs_pkg::ST_WR_CURSOR;
      end
      tccs_pkg::ST_WR_CURSOR: begin
        mem_we    = 1'b1;
        mem_wdata = tccs_pkg::GLYPH_CURSOR;
        state_d   = tccs_pkg::ST_READ;
      end
      tccs_pkg::ST_READ: begin
        mem_re  = 1'b1;
        q_ok_d  = (32'(cmd_q.q_row) < ROWS) && (32'(cmd_q.q_col) < COLS);
        state_d = tccs_pkg::ST_RESP;
      end
      tccs_pkg::ST_RESP: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_glyph_d = q_ok_q ? rdata_q : tccs_pkg::GLYPH_SPACE;
          out_row_d   = tccs_pkg::CROW_W'(row_q);
          out_col_d   = tccs_pkg::CCOL_W'(col_q);
          out_scr_d   = scrolled_q;
          state_d     = tccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccs_pkg::ST_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      scan_q      <= '0;
      clr_q       <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      scan_q      <= scan_d;
      clr_q       <= clr_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    q_ok_q      <= q_ok_d;
    out_glyph_q <= out_glyph_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_scr_q   <= out_scr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Channel  Direction  Handshake             Beat
// in       sink       in_valid_i/in_stall_o  op, char_in, query_row, query_col
// out      source     out_valid_o/out_stall_i cell_glyph, cursor_row, cursor_col, scrolled
//
// Each beat is worked through the single write port of the screen memory: a put
// or backspace writes its cell and the cursor, a line end also blanks the rest of
// the row, and a scroll blanks the new bottom row as well.
// After reset a clearing pass writes ROWS * 2**clog2(COLS) cells (1024 by
// default), one a cycle, while in_stall_o is held high.
// A two-beat queue sits between classification and the memory sequencer, and
// the output register lets the next beat proceed while a result is stalled.
module text_console_cursor_scroll #(
  parameter int ROWS = tccs_pkg::ROWS_DEFAULT,
  parameter int COLS = tccs_pkg::COLS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tccs_pkg::OP_W-1:0]     op_i,
  input  logic [tccs_pkg::CHAR_W-1:0]   char_in_i,
  input  logic [tccs_pkg::QROW_W-1:0]   query_row_i,
  input  logic [tccs_pkg::QCOL_W-1:0]   query_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tccs_pkg::GLYPH_W-1:0]  cell_glyph_o,
  output logic [tccs_pkg::CROW_W-1:0]   cursor_row_o,
  output logic [tccs_pkg::CCOL_W-1:0]   cursor_col_o,
  output logic                          scrolled_o
);

  tccs_pkg::cmd_t front_cmd, queue_cmd;
  logic           push, q_full, q_valid, pop, clearing;

  tccs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .char_in_i   (char_in_i),
    .query_row_i (query_row_i),
    .query_col_i (query_col_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tccs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (queue_cmd)
  );

  tccs_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_glyph_o (cell_glyph_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

// ===== rtl/tccs_checker.sv =====
module tccs_checker #(
  parameter int ROWS = tccs_pkg::ROWS_DEFAULT,
  parameter int COLS = tccs_pkg::COLS_DEFAULT
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [tccs_pkg::OP_W-1:0]     op_i,
  input logic [tccs_pkg::CHAR_W-1:0]   char_in_i,
  input logic [tccs_pkg::QROW_W-1:0]   query_row_i,
  input logic [tccs_pkg::QCOL_W-1:0]   query_col_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tccs_pkg::GLYPH_W-1:0]  cell_glyph_o,
  input logic [tccs_pkg::CROW_W-1:0]   cursor_row_o,
  input logic [tccs_pkg::CCOL_W-1:0]   cursor_col_o,
  input logic                          scrolled_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_glyph_o) &&
      $stable(cursor_row_o) && $stable(cursor_col_o) && $stable(scrolled_o))
    else $error("stalled result beat changed");

  // a scroll leaves the cursor at the start of the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |->
      cursor_col_o == '0 && cursor_row_o == tccs_pkg::CROW_W'(ROWS - 1))
    else $error("scroll with cursor off the bottom row start");

  // every stored glyph is printable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_glyph_o >= tccs_pkg::GLYPH_SPACE)
    else $error("non-printable glyph read back");

  // the cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(cursor_col_o) < COLS && 32'(cursor_row_o) < ROWS)
    else $error("cursor off screen");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tccs_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tccs_pkg::*;

  localparam int ROWS = ROWS_DEFAULT;
  localparam int COLS = COLS_DEFAULT;
  localparam logic [OP_W-1:0] OP_READ = ~OP_PUT;
  localparam int N_ITEMS = 800;
  localparam int TAIL_ITEMS = 120;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_WAIT = 2 * COLS + 16;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [QROW_W-1:0] qrow;
    logic [QCOL_W-1:0] qcol;
    bit                drain_first;
  } term_beat_t;

  typedef struct {
    logic [GLYPH_W-1:0] glyph;
    logic [CROW_W-1:0]  row;
    logic [CCOL_W-1:0]  col;
    logic               scrolled;
  } term_view_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i;
  logic [CHAR_W-1:0]   char_in_i;
  logic [QROW_W-1:0]   query_row_i;
  logic [QCOL_W-1:0]   query_col_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [GLYPH_W-1:0]  cell_glyph_o;
  logic [CROW_W-1:0]   cursor_row_o;
  logic [CCOL_W-1:0]   cursor_col_o;
  logic                scrolled_o;

  text_console_cursor_scroll #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .char_in_i   (char_in_i),
    .query_row_i (query_row_i),
    .query_col_i (query_col_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_glyph_o(cell_glyph_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .scrolled_o  (scrolled_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Screen shadow
  logic [GLYPH_W-1:0] screen_model [ROWS*COLS];
  int top_row;
  int crsr_row;
  int crsr_col;
  bit after_cr;

  term_beat_t pending_beats[$];
  term_view_t expected_views[$];
  bit drain_next;
  bit in_taken = 1'b0;
  int tail_start = N_ITEMS;
  int send_gap = 0;
  int stall_left = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_puts = 0;
  int n_reads = 0;
  int n_scrolls = 0;
  int n_errors = 0;
  int n_cycles = 0;

  function automatic int cell_at(int vrow, int col);
    return ((vrow + top_row) % ROWS) * COLS + col;
  endfunction

  function automatic term_view_t advance_terminal(term_beat_t b);
    term_view_t v;
    v.scrolled = 1'b0;
    if (b.op == OP_PUT) begin
      if (after_cr && b.ch == CH_LF) begin
        after_cr = 1'b0;  // drop the LF of a CR LF pair
      end else begin
        after_cr = (b.ch == CH_CR);
        if (b.ch == CH_BS) begin
          screen_model[cell_at(crsr_row, crsr_col)] = GLYPH_SPACE;
          if (crsr_col != 0) crsr_col--;
        end else begin
          screen_model[cell_at(crsr_row, crsr_col)] =
            (b.ch < CH_SPACE || b.ch > CH_MAX) ? GLYPH_SPACE : b.ch[GLYPH_W-1:0];
          crsr_col++;
          if (b.ch == CH_CR || b.ch == CH_LF || crsr_col >= COLS) begin
            for (int i = crsr_col; i < COLS; i++)
              screen_model[cell_at(crsr_row, i)] = GLYPH_SPACE;
            crsr_row++;
            crsr_col = 0;
            if (crsr_row >= ROWS) begin
              // scroll: bump the top row and clear the new bottom line
              crsr_row = ROWS - 1;
              top_row = (top_row + 1) % ROWS;
              for (int i = 0; i < COLS; i++)
                screen_model[cell_at(crsr_row, i)] = GLYPH_SPACE;
              v.scrolled = 1'b1;
            end
          end
        end
        screen_model[cell_at(crsr_row, crsr_col)] = GLYPH_CURSOR;
      end
    end
    if (b.qrow < ROWS && b.qcol < COLS)
      v.glyph = screen_model[cell_at(b.qrow, b.qcol)];
    else
      v.glyph = GLYPH_SPACE;
    v.row = crsr_row[CROW_W-1:0];
    v.col = crsr_col[CCOL_W-1:0];
    return v;
  endfunction

  task automatic queue_beat(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [QROW_W-1:0] qrow, logic [QCOL_W-1:0] qcol);
    term_beat_t b;
    b.op = op;
    b.ch = ch;
    b.qrow = qrow;
    b.qcol = qcol;
    b.drain_first = drain_next;
    drain_next = 1'b0;
    pending_beats.push_back(b);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Feed one beat per handshake; hold it while stalled
  always @(negedge clk_i) begin : drive
    term_beat_t b;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_taken && n_sent < tail_start && $urandom_range(0, 7) == 0)
        send_gap = $urandom_range(1, 10);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() != 0 &&
                   !(pending_beats[0].drain_first && expected_views.size() != 0)) begin
        b = pending_beats.pop_front();
        op_i        <= b.op;
        char_in_i   <= b.ch;
        query_row_i <= b.qrow;
        query_col_i <= b.qcol;
        in_valid_i  <= 1'b1;
        n_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : backpressure
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (n_results < tail_start && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    term_view_t want;
    term_beat_t b;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result beat, glyph %0d row %0d col %0d scrolled %0d",
                   $time, cell_glyph_o, cursor_row_o, cursor_col_o, scrolled_o);
          n_errors++;
        end else begin
          want = expected_views.pop_front();
          check_field("cell_glyph", int'(want.glyph), int'(cell_glyph_o));
          check_field("cursor_row", int'(want.row), int'(cursor_row_o));
          check_field("cursor_col", int'(want.col), int'(cursor_col_o));
          check_field("scrolled", int'(want.scrolled), int'(scrolled_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        b.op = op_i;
        b.ch = char_in_i;
        b.qrow = query_row_i;
        b.qcol = query_col_i;
        b.drain_first = 1'b0;
        want = advance_terminal(b);
        if (b.op == OP_PUT) n_puts++;
        else n_reads++;
        if (want.scrolled) n_scrolls++;
        expected_views.push_back(want);
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(posedge clk_i) begin : watchdog
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, n_cycles, expected_views.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    op_i = OP_PUT;
    char_in_i = '0;
    query_row_i = '0;
    query_col_i = '0;
    drain_next = 1'b0;
    top_row = 0;
    crsr_row = 0;
    crsr_col = 0;
    after_cr = 1'b0;
    foreach (screen_model[i]) screen_model[i] = GLYPH_SPACE;
    screen_model[0] = GLYPH_CURSOR;

    // Directed: reset screen, byte extremes, backspace, CR/LF handling
    queue_beat(OP_READ, 8'h00, 4'd0, 6'd0);
    queue_beat(OP_READ, 8'hFF, 4'd15, 6'd63);
    queue_beat(OP_PUT, 8'd65, 4'd0, 6'd0);
    queue_beat(OP_PUT, 8'h00, 4'd0, 6'd1);
    queue_beat(OP_PUT, 8'hFF, 4'd0, 6'd2);
    queue_beat(OP_PUT, CH_MAX, 4'd0, 6'd3);
    queue_beat(OP_PUT, CH_SPACE, 4'd0, 6'd4);
    queue_beat(OP_PUT, 8'd128, 4'd0, 6'd5);
    queue_beat(OP_PUT, CH_BS, 4'd0, 6'd5);
    queue_beat(OP_PUT, CH_BS, 4'd0, 6'd4);
    drain_next = 1'b1;
    queue_beat(OP_PUT, CH_CR, 4'd0, 6'd0);
    queue_beat(OP_PUT, CH_LF, 4'd1, 6'd0);
    queue_beat(OP_PUT, CH_LF, 4'd2, 6'd0);
    queue_beat(OP_PUT, CH_CR, 4'd2, 6'd0);
    queue_beat(OP_PUT, CH_CR, 4'd3, 6'd0);
    queue_beat(OP_PUT, CH_BS, 4'd4, 6'd0);
    queue_beat(OP_PUT, 8'd122, 4'd4, 6'd0);
    queue_beat(OP_PUT, 8'd126, 4'd4, 6'd1);
    queue_beat(OP_READ, 8'hAA, 4'd4, 6'd1);
    queue_beat(OP_PUT, 8'h55, 4'd4, 6'd63);
    queue_beat(OP_PUT, CH_LF, 4'd4, 6'd3);
    queue_beat(OP_PUT, 8'd9, 4'd5, 6'd0);

    // Random: mostly text lines, some long lines that wrap, plus noise
    while (pending_beats.size() < N_ITEMS) begin
      if (pending_beats.size() % 200 == 199) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 20);
        repeat (len)
          queue_beat(OP_PUT, CHAR_W'($urandom_range(32, 127)),
                     QROW_W'($urandom), QCOL_W'($urandom));
        case ($urandom_range(0, 4))
          0: queue_beat(OP_PUT, CH_CR, QROW_W'($urandom), QCOL_W'($urandom));
          1: queue_beat(OP_PUT, CH_LF, QROW_W'($urandom), QCOL_W'($urandom));
          2: begin
            queue_beat(OP_PUT, CH_CR, QROW_W'($urandom), QCOL_W'($urandom));
            queue_beat(OP_PUT, CH_LF, QROW_W'($urandom), QCOL_W'($urandom));
          end
          3: begin
            queue_beat(OP_PUT, CH_LF, QROW_W'($urandom), QCOL_W'($urandom));
            queue_beat(OP_PUT, CH_CR, QROW_W'($urandom), QCOL_W'($urandom));
          end
          default: ;
        endcase
      end else if (pick < 63) begin
        len = $urandom_range(COLS - 4, COLS + 6);
        repeat (len)
          queue_beat(OP_PUT, CHAR_W'($urandom_range(32, 127)),
                     QROW_W'($urandom), QCOL_W'($urandom));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4))
          queue_beat(OP_PUT, CH_BS, QROW_W'($urandom), QCOL_W'($urandom));
      end else if (pick < 90) begin
        queue_beat(OP_W'($urandom), CHAR_W'($urandom_range(0, 255)),
                   QROW_W'($urandom), QCOL_W'($urandom));
      end else begin
        queue_beat(OP_READ, CHAR_W'($urandom), QROW_W'($urandom), QCOL_W'($urandom));
      end
    end
    tail_start = pending_beats.size() - TAIL_ITEMS;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Checked %0d results from %0d puts and %0d read-only beats.",
             n_results, n_puts, n_reads);
    $display("Screen scrolled %0d times; %0d mismatches.", n_scrolls, n_errors);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== text_console_cursor_scroll.f =====
rtl/tccs_pkg.sv
rtl/tccs_front.sv
rtl/tccs_fifo.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll.sv
rtl/tccs_checker.sv
bench/tb.sv
